@@ hdl/dkg_pkg.sv @@
// Shared types, permutation tables and helper functions for the DES round key generator.
`timescale 1ns / 1ps

package dkg_pkg;

    // Widths of the key, the C:D halves and one round key.
    localparam int KEY_W   = 64;
    localparam int CD_W    = 56;
    localparam int HALF_W  = 28;
    localparam int RKEY_W  = 48;
    localparam int ROUND_W = 4;
    localparam int ROUNDS  = 16;
    localparam int OUT_W   = 56;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

    // Rotation codes for the key schedule.
    localparam logic [1:0] ROT_ONE = 2'd1;
    localparam logic [1:0] ROT_TWO = 2'd2;

    typedef logic [CD_W-1:0]    cd_t;
    typedef logic [HALF_W-1:0]  half_t;
    typedef logic [RKEY_W-1:0]  rkey_t;
    typedef logic [ROUND_W-1:0] round_t;

    // One C:D word moving between the front end, the queue and the round engine.
    typedef struct packed {
        logic valid;
        cd_t  cd;
    } cd_word_t;

    // Left rotation amount for each round.
    localparam logic [1:0] ROT_SCHED [ROUNDS] = '{
        ROT_ONE, ROT_ONE, ROT_TWO, ROT_TWO, ROT_TWO, ROT_TWO, ROT_TWO, ROT_TWO,
        ROT_ONE, ROT_TWO, ROT_TWO, ROT_TWO, ROT_TWO, ROT_TWO, ROT_TWO, ROT_ONE
    };

    // Key-side permutation table: key bit numbers counted from the key MSB.
    localparam logic [6:0] PC1_TAB [CD_W] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50,
        7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35,
        7'd27, 7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55,
        7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
        7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21,
        7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    // Round-key compression table: C:D bit numbers counted from the C MSB.
    localparam logic [5:0] PC2_TAB [RKEY_W] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,
        6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,
        6'd27, 6'd20, 6'd13, 6'd2,  6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
        6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // The key-side permutation is pure wiring: pick 56 of the 64 key bits.
    function automatic cd_t pc1(input logic [KEY_W-1:0] key);
        cd_t        cd;
        logic [5:0] idx;
        cd  = '0;
        idx = '0;
        for (int i = 0; i < CD_W; i++)
        begin
            idx = 6'(7'(KEY_W) - PC1_TAB[i]);
            cd[CD_W-1-i] = key[idx];
        end
        return cd;
    endfunction

    // The compression permutation is pure wiring: pick 48 of the 56 C:D bits.
    function automatic rkey_t pc2(input cd_t cd);
        rkey_t      k;
        logic [5:0] idx;
        k   = '0;
        idx = '0;
        for (int i = 0; i < RKEY_W; i++)
        begin
            idx = 6'(CD_W) - PC2_TAB[i];
            k[RKEY_W-1-i] = cd[idx];
        end
        return k;
    endfunction

    // Rotate both 28-bit halves left by one or two places.
    function automatic cd_t rotate_cd(input cd_t cd, input logic [1:0] amount);
        half_t c;
        half_t d;
        c = cd[CD_W-1:HALF_W];
        d = cd[HALF_W-1:0];
        if (amount == ROT_TWO)
        begin
            c = {c[HALF_W-3:0], c[HALF_W-1:HALF_W-2]};
            d = {d[HALF_W-3:0], d[HALF_W-1:HALF_W-2]};
        end
        else
        begin
            c = {c[HALF_W-2:0], c[HALF_W-1]};
            d = {d[HALF_W-2:0], d[HALF_W-1]};
        end
        return {c, d};
    endfunction

endpackage

@@ hdl/dkg_front.sv @@
// Input stage: accepts a key word, drops the parity bits by the key permutation, holds C:D.
`timescale 1ns / 1ps

module dkg_front
    import dkg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             key_valid,
    output logic             key_ready,
    input  logic [KEY_W-1:0] key_word,
    output cd_word_t         push,
    input  logic             push_ready
);

    logic valid_reg;
    logic valid_next;
    cd_t  cd_reg;

    // The holding register frees up whenever its word goes into the queue.
    assign key_ready = !valid_reg || push_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (key_valid && key_ready)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (key_valid && key_ready)
        begin
            cd_reg <= pc1(key_word);
        end
    end

    assign push.valid = valid_reg;
    assign push.cd    = cd_reg;

endmodule

@@ hdl/dkg_queue.sv @@
// Short queue of C:D words between the input stage and the round engine.
`timescale 1ns / 1ps

module dkg_queue
    import dkg_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cd_word_t push,
    output logic     push_ready,
    output cd_word_t pop,
    input  logic     pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cd_t              mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign do_push    = push.valid && push_ready;
    assign pop.valid  = (count_reg != '0);
    assign pop.cd     = mem[rd_ptr_reg];
    assign do_pop     = pop.valid && pop_ready;

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.cd;
        end
    end

endmodule

@@ hdl/dkg_back.sv @@
// Round engine: rotates C:D once per round and registers each compressed round key.
`timescale 1ns / 1ps

module dkg_back
    import dkg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cd_word_t pop,
    output logic     pop_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output rkey_t    round_key,
    output round_t   round_number,
    output logic     last_round
);

    logic   active_reg;
    logic   active_next;
    round_t round_reg;
    round_t round_next;
    cd_t    cd_reg;
    cd_t    cd_next;
    cd_t    cd_rot;
    logic   out_valid_reg;
    logic   out_valid_next;
    rkey_t  rkey_reg;
    round_t rnum_reg;
    logic   last_reg;
    logic   emit;
    logic   at_last;

    // Halves for the current round and whether the output register can take its key.
    assign cd_rot  = rotate_cd(cd_reg, ROT_SCHED[round_reg]);
    assign at_last = (round_reg == LAST_ROUND);
    assign emit    = active_reg && (!out_valid_reg || out_ready);

    // Load the next key when idle or as the sixteenth round key leaves.
    assign pop_ready = !active_reg || (emit && at_last);

    always_comb
    begin
        active_next    = active_reg;
        round_next     = round_reg;
        cd_next        = cd_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            cd_next        = cd_rot;
            round_next     = round_reg + 1'b1;
            out_valid_next = 1'b1;
            if (at_last)
            begin
                active_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop.valid && pop_ready)
        begin
            active_next = 1'b1;
            round_next  = '0;
            cd_next     = pop.cd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working halves and output word carry no reset.
    always_ff @(posedge clk)
    begin
        cd_reg <= cd_next;
        if (emit)
        begin
            rkey_reg <= pc2(cd_rot);
            rnum_reg <= round_reg;
            last_reg <= at_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign round_key    = rkey_reg;
    assign round_number = rnum_reg;
    assign last_round   = last_reg;

endmodule

@@ hdl/des_round_key_generator.sv @@
// Top level of the DES round key generator: input stage, word queue and round engine.
//
//  Channel  Direction  Word contents (low bit first)
//  s_axis   in         tdata[63:0] key_word
//  m_axis   out        tdata[47:0] round_key, [51:48] round_number, [55:52] zero;
//                      tlast = last_round
//
// Each key yields sixteen round keys from the round engine's C:D register, one per cycle
// while the output is not stalled. The engine takes the next key as the sixteenth round
// key is registered; up to QUEUE_DEPTH keys plus one in the input stage wait meanwhile.
// From idle, a key passes the input stage, queue and C:D registers to the output register.
// Reset (rst_n low) empties the input stage, the queue and the engine at once.
// Output stalls hold the engine; keys are accepted until queue and input stage are full.
`timescale 1ns / 1ps

module des_round_key_generator
    import dkg_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [KEY_W-1:0] s_axis_tdata,   // key_word
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // round_key, round_number, zero fill
    output logic             m_axis_tlast
);

    cd_word_t push;
    logic     push_ready;
    cd_word_t pop;
    logic     pop_ready;
    rkey_t    round_key;
    round_t   round_number;

    dkg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (s_axis_tvalid),
        .key_ready  (s_axis_tready),
        .key_word   (s_axis_tdata),
        .push       (push),
        .push_ready (push_ready)
    );

    dkg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    dkg_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop          (pop),
        .pop_ready    (pop_ready),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .round_key    (round_key),
        .round_number (round_number),
        .last_round   (m_axis_tlast)
    );

    // Pack the output word with zero fill up to a whole byte.
    assign m_axis_tdata = {{(OUT_W - RKEY_W - ROUND_W){1'b0}}, round_number, round_key};

endmodule
